// ----- sv/smt_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted multiset table package
// Shared request and response types, operation codes and cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package smt_pkg;

    // Default number of table slots.
    localparam int SMT_CAPACITY = 64;

    // Field widths fixed by the request and response formats.
    localparam int FUNC_W  = 3;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    // Operation codes.
    localparam logic [FUNC_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [FUNC_W-1:0] OP_REMOVE   = 3'd1;
    localparam logic [FUNC_W-1:0] OP_FIND     = 3'd2;
    localparam logic [FUNC_W-1:0] OP_COUNT    = 3'd3;
    localparam logic [FUNC_W-1:0] OP_DISTINCT = 3'd4;

    // One request.
    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
    } smt_req_t;

    // One response.
    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] tally;
        logic [COUNT_W-1:0] fill;
        logic               overflow;
    } smt_rsp_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                      compare;
        logic                      do_insert;
        logic                      do_remove;
        logic signed [VALUE_W-1:0] key;
    } smt_cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/smt_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted multiset table cell
// Holds one table entry, compares it with the broadcast key and shifts
// toward or away from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module smt_cell
    import smt_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int OCC_W = 7
) (
    input  wire logic                      aclk,
    input  wire smt_cell_ctrl_t            ctrl,
    input  wire logic [OCC_W-1:0]          occ,
    input  wire logic signed [VALUE_W-1:0] prev_entry,
    input  wire logic                      prev_le,
    input  wire logic signed [VALUE_W-1:0] next_entry,
    output logic signed [VALUE_W-1:0]      entry,
    output logic                           le,
    output logic                           lt,
    output logic                           eq
);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      le_reg, lt_reg, eq_reg;
    logic                      slot_used;

    // The slot is part of the table when its index is below the fill.
    assign slot_used = (OCC_W'(IDX) < occ);

    // Compare stage: flags are masked so that unused slots count as larger.
    always_ff @(posedge aclk) begin
        if (ctrl.compare) begin
            le_reg <= slot_used && (entry_reg <= ctrl.key);
            lt_reg <= slot_used && (entry_reg <  ctrl.key);
            eq_reg <= slot_used && (entry_reg == ctrl.key);
        end
    end

    // Shift stage: insert moves larger entries up, remove pulls entries not below the key down.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.do_insert && !le_reg) begin
            entry_next = prev_le ? ctrl.key : prev_entry;
        end else if (ctrl.do_remove && !lt_reg) begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign le    = le_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire

// ----- sv/smt_scan.sv -----
// ----------------------------------------------------------------------------
// Sorted multiset table boundary scan
// Turns the thermometer-coded compare flags of the cell chain into the
// lower and upper bound slots and a hit flag.
// ----------------------------------------------------------------------------
`default_nettype none

module smt_scan
    import smt_pkg::*;
#(
    parameter int CAPACITY = SMT_CAPACITY,
    parameter int OCC_W    = 7
) (
    input  wire logic [CAPACITY-1:0] le,
    input  wire logic [CAPACITY-1:0] lt,
    input  wire logic [CAPACITY-1:0] eq,
    output logic [OCC_W-1:0]         upper,
    output logic [OCC_W-1:0]         lower,
    output logic                     hit
);

    logic [CAPACITY:0] le_ext;
    logic [CAPACITY:0] lt_ext;

    assign le_ext = {1'b0, le};
    assign lt_ext = {1'b0, lt};

    // The flags form a prefix of ones; the bound is the slot after the last one.
    always_comb begin
        upper = '0;
        lower = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (le_ext[i] && !le_ext[i+1]) begin
                upper = upper | OCC_W'(i + 1);
            end
            if (lt_ext[i] && !lt_ext[i+1]) begin
                lower = lower | OCC_W'(i + 1);
            end
        end
    end

    assign hit = |eq;

endmodule

`default_nettype wire

// ----- sv/sorted_multiset_table.sv -----
// ----------------------------------------------------------------------------
// Sorted multiset table
// Ordered table of signed 32-bit values built as a chain of compare cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_valid/s_ready with s_req (func, value); one response
//   per request leaves on m_valid/m_ready with m_rsp (found, tally, fill,
//   overflow). Operations are insert, remove one, find, count occurrences
//   and count distinct values; codes 5 to 7 change nothing.
//   After a request is accepted it passes a compare step in every cell, a
//   scan and shift step in which the entries past the key position move by
//   one slot on insert or remove, and a step that updates the fill and
//   distinct counters and makes the response valid. The sequencer accepts
//   only in its idle state, so a new request waits until the last is done.
//   The response register lets the next request enter while a response
//   still waits; if the receiver stalls longer, the block holds the finished
//   request in its last step until the response register frees up.
//   Reset empties the table and clears both counters; entry contents are
//   not cleared and need no clearing pass.
//   An insert into a full table is refused and reported with overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_multiset_table
    import smt_pkg::*;
#(
    parameter int CAPACITY = SMT_CAPACITY
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire smt_req_t s_req,
    output logic          m_valid,
    input  wire logic     m_ready,
    output smt_rsp_t      m_rsp
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CMP   = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    smt_req_t         req_reg;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [OCC_W-1:0] distinct_reg, distinct_next;
    logic [OCC_W-1:0] upper_reg, lower_reg;
    logic             hit_reg;
    logic             m_valid_reg, m_valid_next;
    smt_rsp_t         rsp_reg, rsp_next;

    smt_cell_ctrl_t            ctrl;
    logic [CAPACITY-1:0]       le_w, lt_w, eq_w;
    logic signed [VALUE_W-1:0] entry_w [CAPACITY];
    logic [OCC_W-1:0]          upper_w, lower_w;
    logic                      hit_w;
    logic                      full;
    logic                      out_free;
    logic [OCC_W-1:0]          count_w;

    assign full     = (occ_reg == OCC_W'(CAPACITY));
    assign out_free = !m_valid_reg || m_ready;
    assign count_w  = upper_reg - lower_reg;

    // Command broadcast to the cell chain.
    always_comb begin
        ctrl.compare   = (state_reg == ST_CMP);
        ctrl.do_insert = (state_reg == ST_SHIFT) && (req_reg.func == OP_INSERT) && !full;
        ctrl.do_remove = (state_reg == ST_SHIFT) && (req_reg.func == OP_REMOVE) && hit_w;
        ctrl.key       = req_reg.value;
    end

    // Cell chain.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == CAPACITY - 1) ? g : g + 1;

        smt_cell #(
            .IDX   (g),
            .OCC_W (OCC_W)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occ        (occ_reg),
            .prev_entry (entry_w[PREV]),
            .prev_le    ((g == 0) ? 1'b1 : le_w[PREV]),
            .next_entry (entry_w[NEXT]),
            .entry      (entry_w[g]),
            .le         (le_w[g]),
            .lt         (lt_w[g]),
            .eq         (eq_w[g])
        );
    end

    // Bound scan over the compare flags.
    smt_scan #(
        .CAPACITY (CAPACITY),
        .OCC_W    (OCC_W)
    ) u_scan (
        .le    (le_w),
        .lt    (lt_w),
        .eq    (eq_w),
        .upper (upper_w),
        .lower (lower_w),
        .hit   (hit_w)
    );

    // Bounds are registered in the shift cycle.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SHIFT) begin
            upper_reg <= upper_w;
            lower_reg <= lower_w;
            hit_reg   <= hit_w;
        end
    end

    // Request register.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
    end

    // Sequencer, counters and response.
    always_comb begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        distinct_next = distinct_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        rsp_next      = rsp_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next        = ST_IDLE;
                    m_valid_next      = 1'b1;
                    rsp_next.found    = 1'b0;
                    rsp_next.tally    = '0;
                    rsp_next.overflow = 1'b0;
                    case (req_reg.func)
                        OP_INSERT: begin
                            if (full) begin
                                rsp_next.overflow = 1'b1;
                            end else begin
                                occ_next = occ_reg + OCC_W'(1);
                                if (!hit_reg) begin
                                    distinct_next = distinct_reg + OCC_W'(1);
                                end
                            end
                        end
                        OP_REMOVE: begin
                            rsp_next.found = hit_reg;
                            if (hit_reg) begin
                                occ_next = occ_reg - OCC_W'(1);
                                if (count_w == OCC_W'(1)) begin
                                    distinct_next = distinct_reg - OCC_W'(1);
                                end
                            end
                        end
                        OP_FIND: begin
                            rsp_next.found = hit_reg;
                        end
                        OP_COUNT: begin
                            rsp_next.tally = COUNT_W'(32'(count_w));
                        end
                        OP_DISTINCT: begin
                            rsp_next.tally = COUNT_W'(32'(distinct_reg));
                        end
                        default: begin
                        end
                    endcase
                    rsp_next.fill = COUNT_W'(32'(occ_next));
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            distinct_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            distinct_reg <= distinct_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rsp_reg <= rsp_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

    // The fill never passes the capacity.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("fill above capacity");

    // There are never more distinct values than entries.
    a_distinct_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        distinct_reg <= occ_reg)
        else $error("distinct count above fill");

    // An empty table has no distinct values and a filled one has some.
    a_distinct_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (distinct_reg == '0) == (occ_reg == '0))
        else $error("distinct count disagrees with fill");

    // The scanned bounds are ordered once they are used.
    a_bounds_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (lower_reg <= upper_reg))
        else $error("lower bound above upper bound");

endmodule

`default_nettype wire
